// ----- rtl/core/g2u_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the GB2312 to UTF-8 converter core.
// No dependencies.
package g2u_pkg;

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // UTF-8 range limits and lead/continuation markers
  localparam logic [15:0] UTF_MAX1  = 16'h007F;
  localparam logic [15:0] UTF_MAX2  = 16'h07FF;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  MASK_6    = 8'h3F;
  localparam logic [7:0]  MASK_5    = 8'h1F;
  localparam logic [7:0]  MASK_4    = 8'h0F;

  localparam int CFG_W = 14;
  localparam int IDX_W = 13;

endpackage

// ----- rtl/core/g2u_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module g2u_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gb2312_to_utf8_converter_core.sv -----
`timescale 1ns / 1ps
// GB2312 to UTF-8 converter top level: sequencer, binary search and output register.
// Depends on g2u_pkg and g2u_ram.
//
// Usage:
//  Input items (in_valid / in_stall) are either table loads (in_req_type 0) or
//  text bytes (in_req_type 1). Loads write one mapping entry and give no result.
//  The table must be sorted by GB2312 code; cfg_wr_en/cfg_wr_data set how many
//  entries are searched (capped at TABLE_DEPTH); the user must write them only
//  while the core is idle, which the core does not enforce. A byte below 0x80
//  is buffered, then sent as one UTF-8 item. A lead byte is held unless it has
//  in_final_byte set; the next byte forms the key, which is binary searched, one
//  table read per cycle from the RAM read port, at most ceil(log2(n+1)) probes
//  for n entries (14 for 8192). The found value is then sent as one to three
//  items, one per cycle while out_stall is low. in_stall is high while a
//  character is searched or sent; the next item is taken as soon as the last
//  byte sits in the output register. out_stall holds the output register and
//  the sequencer waits behind it. Reset (synchronous, rst_n low) clears the
//  pending lead byte, the entry count and out_valid; the table is not cleared.
module gb2312_to_utf8_converter_core
  import g2u_pkg::*;
#(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [15:0]      in_entry_gb_code,
  input  logic [15:0]      in_entry_unicode,
  input  logic [7:0]       in_data_byte,
  input  logic             in_final_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic             out_lookup_miss
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 2;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r, cfg_nxt;
  logic                lead_pending_r, lead_pending_nxt;
  logic [7:0]          lead_byte_r, lead_byte_nxt;
  logic [15:0]         key_r, key_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [7:0]          em_byte_r [3];
  logic [7:0]          em_byte_nxt [3];
  logic [1:0]          em_cnt_r, em_cnt_nxt;
  logic                em_miss_r, em_miss_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_miss_r, out_miss_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         ram_rdata;
  logic [16:0]         idx_ext;
  logic signed [SW-1:0] n_sat, mid_s, lo_c, hi_c, mid_c;
  logic [15:0]         g_code, u_val;

  assign idx_ext = 17'(in_entry_index);
  assign g_code  = ram_rdata[31:16];
  assign u_val   = ram_rdata[15:0];
  assign mid_s   = $signed({2'b00, mid_r});

  always_comb begin
    if (32'(cfg_r) > TABLE_DEPTH) begin
      n_sat = SW'(TABLE_DEPTH);
    end else begin
      n_sat = SW'(cfg_r);
    end
  end

  // Loads only happen in idle, so a write never overlaps a search read.
  g2u_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_ext[AW-1:0]),
    .wdata({in_entry_gb_code, in_entry_unicode}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt        = state_r;
    cfg_nxt          = cfg_r;
    lead_pending_nxt = lead_pending_r;
    lead_byte_nxt    = lead_byte_r;
    key_nxt          = key_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    em_byte_nxt      = em_byte_r;
    em_cnt_nxt       = em_cnt_r;
    em_miss_nxt      = em_miss_r;
    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_last_nxt     = out_last_r;
    out_miss_nxt     = out_miss_r;
    ram_we           = 1'b0;
    ram_raddr        = mid_r;
    lo_c             = lo_r;
    hi_c             = hi_r;
    mid_c            = '0;

    if (cfg_wr_en) begin
      cfg_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_req_type) begin
            if (idx_ext < 17'(TABLE_DEPTH)) begin
              ram_we = 1'b1;
            end
          end else if (!lead_pending_r) begin
            if (!in_data_byte[7]) begin
              em_byte_nxt[0] = in_data_byte;
              em_cnt_nxt     = 2'd1;
              em_miss_nxt    = 1'b0;
              state_nxt      = ST_EMIT;
            end else if (!in_final_byte) begin
              lead_pending_nxt = 1'b1;
              lead_byte_nxt    = in_data_byte;
            end
          end else begin
            lead_pending_nxt = 1'b0;
            key_nxt          = {lead_byte_r, in_data_byte};
            if (n_sat == '0) begin
              em_byte_nxt[0] = 8'h00;
              em_cnt_nxt     = 2'd1;
              em_miss_nxt    = 1'b1;
              state_nxt      = ST_EMIT;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = n_sat - SW'(1);
              mid_c     = (n_sat - SW'(1)) >>> 1;
              mid_nxt   = mid_c[AW-1:0];
              ram_raddr = mid_c[AW-1:0];
              state_nxt = ST_SRCH;
            end
          end
        end
      end

      ST_SRCH: begin
        if (g_code == key_r) begin
          em_miss_nxt = 1'b0;
          if (u_val <= UTF_MAX1) begin
            em_byte_nxt[0] = u_val[7:0];
            em_cnt_nxt     = 2'd1;
          end else if (u_val <= UTF_MAX2) begin
            em_byte_nxt[0] = (u_val[13:6] & MASK_5) | UTF_LEAD2;
            em_byte_nxt[1] = (u_val[7:0] & MASK_6) | UTF_CONT;
            em_cnt_nxt     = 2'd2;
          end else begin
            em_byte_nxt[0] = (u_val[15:8] >> 4) | UTF_LEAD3;
            em_byte_nxt[1] = (u_val[13:6] & MASK_6) | UTF_CONT;
            em_byte_nxt[2] = (u_val[7:0] & MASK_6) | UTF_CONT;
            em_cnt_nxt     = 2'd3;
          end
          state_nxt = ST_EMIT;
        end else begin
          if (g_code > key_r) begin
            hi_c = mid_s - SW'(1);
          end else begin
            lo_c = mid_s + SW'(1);
          end
          lo_nxt = lo_c;
          hi_nxt = hi_c;
          if (lo_c <= hi_c) begin
            mid_c     = (lo_c + hi_c) >>> 1;
            mid_nxt   = mid_c[AW-1:0];
            ram_raddr = mid_c[AW-1:0];
          end else begin
            em_byte_nxt[0] = 8'h00;
            em_cnt_nxt     = 2'd1;
            em_miss_nxt    = 1'b1;
            state_nxt      = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = em_byte_r[0];
          out_last_nxt   = (em_cnt_r == 2'd1);
          out_miss_nxt   = em_miss_r;
          em_byte_nxt[0] = em_byte_r[1];
          em_byte_nxt[1] = em_byte_r[2];
          em_cnt_nxt     = em_cnt_r - 2'd1;
          if (em_cnt_r == 2'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cfg_r          <= '0;
      lead_pending_r <= 1'b0;
      lead_byte_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cfg_r          <= cfg_nxt;
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    em_byte_r   <= em_byte_nxt;
    em_cnt_r    <= em_cnt_nxt;
    em_miss_r   <= em_miss_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_miss_r  <= out_miss_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_lookup_miss = out_miss_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gb2312_to_utf8_converter_core: loads the mapping
// table, streams GB2312 text and checks every UTF-8 item. Depends on g2u_pkg and the core.
module tb
  import g2u_pkg::*;
();

  localparam int DEPTH        = 8192;
  // Loaded table: a dense region at the bottom plus the entries on the leftmost
  // search path over the whole table (REGION + 1 is a power of two). Path codes
  // lie above every other code, so no search over REGION or fewer entries, or
  // over the whole table, ever probes an unloaded entry.
  localparam int REGION       = 63;
  localparam int SPINE        = 7;
  localparam int TOP_IDX      = DEPTH / 2 - 1;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_PRINTS   = 40;
  localparam bit REQ_LOAD     = 1'b0;
  localparam bit REQ_TEXT     = 1'b1;

  typedef struct {
    bit        req_type;
    bit [12:0] idx;
    bit [15:0] gb;
    bit [15:0] uni;
    bit [7:0]  data;
    bit        fin;
    int        gap;
  } gb_item_t;

  typedef struct {
    bit [7:0] b;
    bit       last;
    bit       miss;
  } utf8_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = 1'b0;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic [15:0]      in_entry_gb_code = '0;
  logic [15:0]      in_entry_unicode = '0;
  logic [7:0]       in_data_byte = '0;
  logic             in_final_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last_of_run;
  logic             out_lookup_miss;

  gb2312_to_utf8_converter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_entry_gb_code (in_entry_gb_code),
    .in_entry_unicode (in_entry_unicode),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_lookup_miss  (out_lookup_miss)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the converter state
  bit [15:0]   tab_gb [DEPTH];
  bit [15:0]   tab_uni[DEPTH];
  bit          lead_held = 1'b0;
  bit [7:0]    lead_val = '0;
  int unsigned entries_cfg;

  gb_item_t    gb_items[$];
  utf8_byte_t  utf8_expected[$];
  gb_item_t    cur_item;
  int          idle_ctr;
  int          rx_wait;
  int          hold_left;
  bit          hold_go = 1'b0;
  bit          quiet;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic bit find_unicode(input bit [15:0] key, output bit [15:0] val);
    int n, lo, hi, mid;
    n = (entries_cfg > DEPTH) ? DEPTH : int'(entries_cfg);
    lo = 0;
    hi = n - 1;
    val = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tab_gb[mid] == key) begin
        val = tab_uni[mid];
        return 1'b1;
      end
      if (tab_gb[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  task automatic push_utf8(input bit [7:0] b, input bit last, input bit miss);
    utf8_byte_t r;
    r.b    = b;
    r.last = last;
    r.miss = miss;
    utf8_expected.push_back(r);
  endtask

  // Expected UTF-8 items for one accepted item
  task automatic transcode_item(input gb_item_t it);
    bit [15:0] key, u;
    if (it.req_type == REQ_LOAD) begin
      tab_gb[it.idx]  = it.gb;
      tab_uni[it.idx] = it.uni;
    end else if (!lead_held) begin
      if (!it.data[7]) push_utf8(it.data, 1'b1, 1'b0);
      else if (!it.fin) begin
        lead_held = 1'b1;
        lead_val  = it.data;
      end
    end else begin
      lead_held = 1'b0;
      key = {lead_val, it.data};
      if (!find_unicode(key, u)) begin
        push_utf8(8'h00, 1'b1, 1'b1);
      end else if (u <= UTF_MAX1) begin
        push_utf8(u[7:0], 1'b1, 1'b0);
      end else if (u <= UTF_MAX2) begin
        push_utf8({3'b110, u[10:6]}, 1'b0, 1'b0);
        push_utf8({2'b10, u[5:0]}, 1'b1, 1'b0);
      end else begin
        push_utf8({4'b1110, u[15:12]}, 1'b0, 1'b0);
        push_utf8({2'b10, u[11:6]}, 1'b0, 1'b0);
        push_utf8({2'b10, u[5:0]}, 1'b1, 1'b0);
      end
    end
  endtask

  // Sender: takes pending items in order, idling for each item's drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_ctr <= 0;
    end else begin
      if (in_valid && !in_stall) transcode_item(cur_item);
      if (!in_valid || !in_stall) begin
        if (gb_items.size() != 0 && idle_ctr >= gb_items[0].gap) begin
          cur_item = gb_items.pop_front();
          in_valid         <= 1'b1;
          in_req_type      <= cur_item.req_type;
          in_entry_index   <= cur_item.idx;
          in_entry_gb_code <= cur_item.gb;
          in_entry_unicode <= cur_item.uni;
          in_data_byte     <= cur_item.data;
          in_final_byte    <= cur_item.fin;
          idle_ctr         <= 0;
        end else begin
          in_valid <= 1'b0;
          if (gb_items.size() != 0) idle_ctr <= idle_ctr + 1;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver: checks each UTF-8 item, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    int w;
    utf8_byte_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid === 1'b1 && !out_stall) begin
      if (utf8_expected.size() == 0) begin
        report_mismatch("item with nothing pending, byte", int'(out_byte), 0);
      end else begin
        e = utf8_expected.pop_front();
        if (out_byte !== e.b)
          report_mismatch("out_byte", int'(out_byte), int'(e.b));
        if (out_last_of_run !== e.last)
          report_mismatch("last_of_run", int'(out_last_of_run), int'(e.last));
        if (out_lookup_miss !== e.miss)
          report_mismatch("lookup_miss", int'(out_lookup_miss), int'(e.miss));
      end
      w = quiet ? 0 : $urandom_range(0, 7);
      rx_wait   <= w;
      out_stall <= (w != 0) || (hold_left != 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait != 1) || (hold_left != 0);
    end else begin
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_item(input bit t, input bit [12:0] idx, input bit [15:0] gb,
                           input bit [15:0] uni, input bit [7:0] data, input bit fin);
    gb_item_t it;
    it.req_type = t;
    it.idx      = idx;
    it.gb       = gb;
    it.uni      = uni;
    it.data     = data;
    it.fin      = fin;
    it.gap      = quiet ? 0 : $urandom_range(0, 7);
    gb_items.push_back(it);
  endtask

  task automatic push_text(input bit [7:0] data, input bit fin);
    push_item(REQ_TEXT, 13'($urandom), 16'($urandom), 16'($urandom), data, fin);
  endtask

  task automatic push_load(input bit [12:0] idx, input bit [15:0] gb, input bit [15:0] uni);
    push_item(REQ_LOAD, idx, gb, uni, 8'($urandom), 1'($urandom));
  endtask

  // Lead byte never carries the final flag, otherwise it is dropped
  task automatic push_pair(input bit [15:0] key, input bit fin);
    push_text(key[15:8], 1'b0);
    push_text(key[7:0], fin);
  endtask

  function automatic bit [15:0] rand_unicode();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      default: return 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (gb_items.size() != 0 || in_valid || utf8_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Entry counts used: up to REGION, exactly DEPTH, or above DEPTH
  task automatic write_entries(input int unsigned n);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    entries_cfg = n;
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int eff, r, j;
    bit [15:0] key;
    eff = (entries_cfg > REGION) ? REGION : int'(entries_cfg);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      key = 16'($urandom);
      key[15] = 1'b1;
      if (eff > 1 && ((r >= 30 && r < 72) || r >= 96))
        key = tab_gb[$urandom_range(1, eff - 1)];
      if (r < 30) begin
        push_text(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
      end else if (r < 86) begin
        push_pair(key, $urandom_range(0, 7) == 0);
      end else if (r < 92) begin
        push_text(8'h80 | 8'($urandom), 1'b1);
      end else if (r < 96) begin
        j = $urandom_range(0, REGION - 1);
        push_load(13'(j), tab_gb[j], rand_unicode());
      end else begin
        // table rewrite between lead and trail byte; codes stay sorted
        j = $urandom_range(0, REGION - 1);
        push_text(key[15:8], 1'b0);
        push_load(13'(j), tab_gb[j], rand_unicode());
        push_text(key[7:0], 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    bit [15:0] code, uni;
    entries_cfg    = 0;
    quiet          = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Entry count zero after reset: every double-byte code misses
    push_text(8'h00, 1'b0);
    push_text(8'h7F, 1'b0);
    push_pair(16'h8000, 1'b0);
    push_text(8'hFF, 1'b1);
    push_text(8'h41, 1'b1);
    push_text(8'h90, 1'b0);
    push_load(13'h1FFF, 16'hFFFF, 16'hFFFF);
    push_text(8'hFF, 1'b0);
    push_load(13'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // Sorted region and search path, back to back
    quiet = 1'b1;
    for (int i = 0; i < REGION; i++) begin
      code = 16'(16'h8000 + 4 * i + $urandom_range(0, 3));
      if (i == 0) code = 16'h0000;
      case (i)
        1:       uni = 16'h0000;
        2:       uni = 16'h007F;
        3:       uni = 16'h0080;
        4:       uni = 16'h07FF;
        5:       uni = 16'h0800;
        6:       uni = 16'h0041;
        default: uni = rand_unicode();
      endcase
      push_load(13'(i), code, uni);
    end
    for (int s = 0; s < SPINE; s++) begin
      uni = (s == SPINE - 1) ? 16'hFFFF : rand_unicode();
      push_load(13'((REGION + 1) * (1 << s) - 1), 16'(16'hFFF9 + s), uni);
    end
    wait_idle();
    quiet = 1'b0;

    write_entries(DEPTH);
    push_pair(tab_gb[1], 1'b0);
    push_pair(tab_gb[2], 1'b0);
    push_pair(tab_gb[3], 1'b0);
    push_pair(tab_gb[4], 1'b0);
    push_pair(tab_gb[5], 1'b0);
    push_pair(tab_gb[6], 1'b1);
    push_pair(tab_gb[7], 1'b0);
    push_pair(tab_gb[TOP_IDX], 1'b0);
    push_pair({tab_gb[40][15:2], ~tab_gb[40][1:0]}, 1'b0);
    push_text(8'h7F, 1'b1);
    run_random(25);
    wait_idle();

    // Oversized count, with the receiver holding off while the sender keeps going
    write_entries(16383);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    @(negedge clk);
    run_random(25);
    wait_idle();

    write_entries(1);
    run_random(12);
    wait_idle();

    write_entries(0);
    run_random(12);
    wait_idle();

    write_entries($urandom_range(2, REGION));
    quiet = 1'b1;
    run_random(20);
    wait_idle();
    quiet = 1'b0;

    write_entries(DEPTH);
    run_random(20);
    wait_idle();

    write_entries(3);
    run_random(12);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- gb2312_to_utf8_converter_core.f -----
rtl/core/g2u_pkg.sv
rtl/core/g2u_ram.sv
rtl/core/gb2312_to_utf8_converter_core.sv
dv/tb.sv
